FILE: sv/pbnm_pkg.sv
// Package for the palette blend and nearest match block: widths, types, codes and default colors.
`default_nettype none

package pbnm_pkg;

    // Palette size and derived widths.
    localparam int PALETTE_ENTRIES = 32;
    localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
    localparam int FIELD_IDX_W     = 5;
    localparam int CHAN_W          = 8;
    localparam int RATIO_W         = 7;
    localparam int PROD_W          = CHAN_W + RATIO_W;
    localparam int SQ_W            = 2 * CHAN_W;
    localparam int DIST_W          = SQ_W + 2;
    localparam int NUM_CHAN        = 3;

    // Blend constants: divide by one hundred through a reciprocal multiply.
    localparam logic [RATIO_W-1:0] FULL_PERCENT = RATIO_W'(100);
    localparam int                 RECIP_W      = 13;
    localparam int                 RECIP_SHIFT  = 19;
    localparam logic [RECIP_W-1:0] RECIP_100    = RECIP_W'(5243);
    localparam int                 QPROD_W      = PROD_W + RECIP_W;

    // Request codes.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_MIX  = 1'b1;

    // A color: index 2 is red, 1 is green, 0 is blue.
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] color_t;

    // Palette write broadcast to every cell.
    typedef struct packed {
        logic                   en;
        logic [FIELD_IDX_W-1:0] index;
        color_t                 color;
    } wr_t;

    // Token that gathers the two mix colors on its way down the chain.
    typedef struct packed {
        logic   valid;
        color_t ca;
        color_t cb;
    } fetch_tok_t;

    // Token that carries the best distance so far and its entry.
    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  idx;
    } search_tok_t;

    // Sequencer states of the top level.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL,
        ST_SUM,
        ST_RECIP,
        ST_SQUARE,
        ST_DIST,
        ST_SEARCH,
        ST_HOLD
    } state_t;

    // Reset color of each palette entry; entries past the default set are black.
    function automatic color_t default_color(input int i);
        color_t c;
        case (i)
            0:       c = {8'd255, 8'd0,   8'd0};
            1:       c = {8'd0,   8'd255, 8'd0};
            2:       c = {8'd0,   8'd0,   8'd255};
            3:       c = {8'd255, 8'd255, 8'd0};
            4:       c = {8'd0,   8'd255, 8'd255};
            5:       c = {8'd255, 8'd0,   8'd255};
            6:       c = {8'd255, 8'd255, 8'd255};
            7:       c = {8'd0,   8'd0,   8'd0};
            8:       c = {8'd255, 8'd165, 8'd0};
            9:       c = {8'd128, 8'd0,   8'd128};
            10:      c = {8'd255, 8'd192, 8'd203};
            11:      c = {8'd139, 8'd69,  8'd19};
            12:      c = {8'd128, 8'd128, 8'd128};
            13:      c = {8'd50,  8'd205, 8'd50};
            14:      c = {8'd0,   8'd128, 8'd128};
            15:      c = {8'd0,   8'd0,   8'd128};
            16:      c = {8'd128, 8'd0,   8'd0};
            17:      c = {8'd128, 8'd128, 8'd0};
            18:      c = {8'd192, 8'd192, 8'd192};
            19:      c = {8'd255, 8'd127, 8'd80};
            20:      c = {8'd255, 8'd215, 8'd0};
            21:      c = {8'd238, 8'd130, 8'd238};
            22:      c = {8'd75,  8'd0,   8'd130};
            23:      c = {8'd64,  8'd224, 8'd208};
            24:      c = {8'd250, 8'd128, 8'd114};
            25:      c = {8'd221, 8'd160, 8'd221};
            26:      c = {8'd210, 8'd180, 8'd140};
            27:      c = {8'd240, 8'd230, 8'd140};
            28:      c = {8'd230, 8'd230, 8'd250};
            29:      c = {8'd189, 8'd252, 8'd201};
            30:      c = {8'd255, 8'd229, 8'd180};
            31:      c = {8'd135, 8'd206, 8'd235};
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: sv/pbnm_cell.sv
// One palette cell: holds an entry, picks it into the fetch token and compares it in the search.
`default_nettype none

module pbnm_cell
    import pbnm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [IDX_W-1:0]       cell_index,
    input  wire color_t                 init_color,
    input  wire wr_t                    wr,
    input  wire logic [FIELD_IDX_W-1:0] sel_a,
    input  wire logic [FIELD_IDX_W-1:0] sel_b,
    input  wire color_t                 mix,
    input  wire fetch_tok_t             fetch_in,
    output fetch_tok_t                  fetch_out,
    input  wire search_tok_t            search_in,
    output search_tok_t                 search_out
);

    color_t                         entry_reg;
    logic [NUM_CHAN-1:0][SQ_W-1:0]  sq_reg;
    logic [NUM_CHAN-1:0][SQ_W-1:0]  sq_next;
    logic [DIST_W-1:0]              dist_reg;
    logic [DIST_W-1:0]              dist_next;
    fetch_tok_t                     fetch_reg;
    fetch_tok_t                     fetch_next;
    search_tok_t                    search_reg;
    search_tok_t                    search_next;
    logic                           hit_wr;
    logic                           hit_a;
    logic                           hit_b;

    // Address decode against this cell's own place in the row.
    assign hit_wr = wr.en && (int'(wr.index) == int'(cell_index));
    assign hit_a  = (int'(sel_a) == int'(cell_index));
    assign hit_b  = (int'(sel_b) == int'(cell_index));

    // Palette entry, loaded with its default color at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= init_color;
        end
        else if (hit_wr)
        begin
            entry_reg <= wr.color;
        end
    end

    // Squared channel differences against the broadcast mix color.
    always_comb
    begin
        logic [CHAN_W-1:0] diff;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            diff = (entry_reg[c] > mix[c]) ? (entry_reg[c] - mix[c]) : (mix[c] - entry_reg[c]);
            sq_next[c] = SQ_W'(diff) * SQ_W'(diff);
        end
    end

    // Sum of the three squares.
    assign dist_next = DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);

    always_ff @(posedge clk)
    begin
        sq_reg   <= sq_next;
        dist_reg <= dist_next;
    end

    // Fetch step: take this entry as color a or b when selected.
    always_comb
    begin
        fetch_next       = fetch_in;
        fetch_next.ca    = hit_a ? entry_reg : fetch_in.ca;
        fetch_next.cb    = hit_b ? entry_reg : fetch_in.cb;
    end

    // Search step: a strictly smaller distance replaces the best so far.
    always_comb
    begin
        search_next = search_in;
        if (dist_reg < search_in.distance)
        begin
            search_next.distance = dist_reg;
            search_next.idx      = cell_index;
        end
    end

    // Token registers, cleared at reset so that no token walks the row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fetch_reg  <= '0;
            search_reg <= '0;
        end
        else
        begin
            fetch_reg  <= fetch_next;
            search_reg <= search_next;
        end
    end

    assign fetch_out  = fetch_reg;
    assign search_out = search_reg;

endmodule

`default_nettype wire

FILE: sv/palette_blend_nearest_match.sv
// Top level: request sequencer, blend datapath, output register and the row of palette cells.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+---------------------------------------------------------
//  in      | in_valid/in_ready  | req_type, slot_*, color_a_index, color_b_index, mix_ratio
//  out     | out_valid/out_ready| mixed_red, mixed_green, mixed_blue, nearest_index
//
// A load item writes its cell at the accepting edge.
// A mix item runs in steps: one token walks the cell row to gather both colors, the multiply,
// sum, reciprocal, square and distance states blend and square, a second token walks the row
// to find the nearest entry, and the hold state moves the result to the output register.
// Reset (rst_n low) restores the default palette at once; no clearing pass is needed.
// A stalled output holds its item; a new item is still taken while it waits, and a finished
// mix waits in the hold state until the output register is free.
`default_nettype none

module palette_blend_nearest_match
    import pbnm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   req_type,
    input  wire logic [FIELD_IDX_W-1:0] slot_index,
    input  wire logic [CHAN_W-1:0]      slot_red,
    input  wire logic [CHAN_W-1:0]      slot_green,
    input  wire logic [CHAN_W-1:0]      slot_blue,
    input  wire logic [FIELD_IDX_W-1:0] color_a_index,
    input  wire logic [FIELD_IDX_W-1:0] color_b_index,
    input  wire logic [RATIO_W-1:0]     mix_ratio,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [CHAN_W-1:0]           mixed_red,
    output logic [CHAN_W-1:0]           mixed_green,
    output logic [CHAN_W-1:0]           mixed_blue,
    output logic [FIELD_IDX_W-1:0]      nearest_index
);

    state_t                          state_reg;
    state_t                          state_next;
    logic [FIELD_IDX_W-1:0]          a_idx_reg;
    logic [FIELD_IDX_W-1:0]          b_idx_reg;
    logic [RATIO_W-1:0]              ratio_reg;
    logic [RATIO_W-1:0]              ratio_next;
    color_t                          ca_reg;
    color_t                          cb_reg;
    logic [NUM_CHAN-1:0][PROD_W-1:0] prod_a_reg;
    logic [NUM_CHAN-1:0][PROD_W-1:0] prod_b_reg;
    logic [NUM_CHAN-1:0][PROD_W-1:0] prod_a_next;
    logic [NUM_CHAN-1:0][PROD_W-1:0] prod_b_next;
    logic [NUM_CHAN-1:0][PROD_W-1:0] sum_reg;
    logic [NUM_CHAN-1:0][PROD_W-1:0] sum_next;
    color_t                          mix_reg;
    color_t                          mix_next;
    logic [IDX_W-1:0]                near_reg;
    logic                            fetch_go_reg;
    logic                            search_go_reg;
    logic                            out_valid_reg;
    color_t                          out_color_reg;
    logic [FIELD_IDX_W-1:0]          out_index_reg;
    logic [RATIO_W-1:0]              inv_ratio;

    logic                            take_item;
    logic                            take_mix;
    logic                            grab_colors;
    logic                            grab_nearest;
    logic                            load_out;
    logic                            launch_search;
    wr_t                             wr_bus;

    fetch_tok_t                      fetch_chain  [PALETTE_ENTRIES+1];
    search_tok_t                     search_chain [PALETTE_ENTRIES+1];
    fetch_tok_t                      fetch_last;
    search_tok_t                     search_last;

    assign fetch_last  = fetch_chain[PALETTE_ENTRIES];
    assign search_last = search_chain[PALETTE_ENTRIES];

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (req_type == REQ_MIX))
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (fetch_last.valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:    state_next = ST_SUM;
            ST_SUM:    state_next = ST_RECIP;
            ST_RECIP:  state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_DIST;
            ST_DIST:   state_next = ST_SEARCH;
            ST_SEARCH:
            begin
                if (search_last.valid)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready      = 1'b0;
        grab_colors   = 1'b0;
        grab_nearest  = 1'b0;
        load_out      = 1'b0;
        launch_search = 1'b0;
        case (state_reg)
            ST_IDLE:   in_ready      = 1'b1;
            ST_FETCH:  grab_colors   = fetch_last.valid;
            ST_DIST:   launch_search = 1'b1;
            ST_SEARCH: grab_nearest  = search_last.valid;
            ST_HOLD:   load_out      = !out_valid_reg || out_ready;
            default:   in_ready      = 1'b0;
        endcase
    end

    assign take_item = in_valid && in_ready;
    assign take_mix  = take_item && (req_type == REQ_MIX);

    // Palette write broadcast for a load item.
    assign wr_bus.en    = take_item && (req_type == REQ_LOAD);
    assign wr_bus.index = slot_index;
    assign wr_bus.color = {slot_red, slot_green, slot_blue};

    // Ratio saturates at one hundred percent.
    assign ratio_next = (mix_ratio > FULL_PERCENT) ? FULL_PERCENT : mix_ratio;
    assign inv_ratio  = FULL_PERCENT - ratio_reg;

    // Blend datapath: products, sums, then division by one hundred via reciprocal.
    always_comb
    begin
        logic [QPROD_W-1:0] q;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            prod_a_next[c] = PROD_W'(ca_reg[c]) * PROD_W'(inv_ratio);
            prod_b_next[c] = PROD_W'(cb_reg[c]) * PROD_W'(ratio_reg);
            sum_next[c]    = prod_a_reg[c] + prod_b_reg[c];
            q              = QPROD_W'(sum_reg[c]) * QPROD_W'(RECIP_100);
            mix_next[c]    = q[RECIP_SHIFT +: CHAN_W];
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fetch_go_reg  <= 1'b0;
            search_go_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fetch_go_reg  <= take_mix;
            search_go_reg <= launch_search;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take_mix)
        begin
            a_idx_reg <= color_a_index;
            b_idx_reg <= color_b_index;
            ratio_reg <= ratio_next;
        end
        if (grab_colors)
        begin
            ca_reg <= fetch_last.ca;
            cb_reg <= fetch_last.cb;
        end
        if (state_reg == ST_MUL)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
        end
        if (state_reg == ST_SUM)
        begin
            sum_reg <= sum_next;
        end
        if (state_reg == ST_RECIP)
        begin
            mix_reg <= mix_next;
        end
        if (grab_nearest)
        begin
            near_reg <= search_last.idx;
        end
        if (load_out)
        begin
            out_color_reg <= mix_reg;
            out_index_reg <= FIELD_IDX_W'(near_reg);
        end
    end

    // Tokens enter the row at cell zero; unselected colors read as black.
    assign fetch_chain[0]           = '{valid: fetch_go_reg, ca: '0, cb: '0};
    assign search_chain[0].valid    = search_go_reg;
    assign search_chain[0].distance = '1;
    assign search_chain[0].idx      = '0;

    // The row of palette cells, index zero first so the lowest index wins a tie.
    for (genvar g = 0; g < PALETTE_ENTRIES; g++)
    begin : g_cell
        pbnm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (IDX_W'(g)),
            .init_color (default_color(g)),
            .wr         (wr_bus),
            .sel_a      (a_idx_reg),
            .sel_b      (b_idx_reg),
            .mix        (mix_reg),
            .fetch_in   (fetch_chain[g]),
            .fetch_out  (fetch_chain[g+1]),
            .search_in  (search_chain[g]),
            .search_out (search_chain[g+1])
        );
    end

    assign out_valid     = out_valid_reg;
    assign mixed_red     = out_color_reg[2];
    assign mixed_green   = out_color_reg[1];
    assign mixed_blue    = out_color_reg[0];
    assign nearest_index = out_index_reg;

`ifndef SYNTH
    logic [PALETTE_ENTRIES-1:0] fetch_vld;
    logic [PALETTE_ENTRIES-1:0] search_vld;

    for (genvar v = 0; v < PALETTE_ENTRIES; v++)
    begin : g_vld
        assign fetch_vld[v]  = fetch_chain[v+1].valid;
        assign search_vld[v] = search_chain[v+1].valid;
    end

    // At most one token of each kind walks the row.
    a_one_token : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(fetch_vld) && $onehot0(search_vld))
        else $error("more than one token in the cell row");

    // A new item is taken only when no token is in flight.
    a_idle_clear : assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (fetch_vld == '0) && (search_vld == '0))
        else $error("item accepted while a token is in the row");

    // A fetch token reaches the end of the row only while the sequencer waits for it.
    a_fetch_state : assert property (@(posedge clk) disable iff (!rst_n)
        fetch_last.valid |-> (state_reg == ST_FETCH))
        else $error("fetch token arrived outside the fetch state");

    // A result appears only after the hold state.
    a_result_src : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_HOLD))
        else $error("result item raised outside the hold state");
`endif

endmodule

`default_nettype wire
